// ===== design/sha256_pkg.sv =====
// Shared types and constants for the SHA-256 stream hasher.
`default_nettype none

package sha256_pkg;

   // One input transfer as it appears on the request channel.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_data;
      logic       finish;
   } req_type;

   // One digest word as it appears on the response channel.
   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // Classified work items that travel from the front end to the engine.
   typedef enum logic [1:0] {
      CMD_BYTE      = 2'd0,
      CMD_LAST_BYTE = 2'd1,
      CMD_FINISH    = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data_byte;
   } cmd_type;

   // Padding marker byte.
   localparam logic [7:0] PAD_MARK = 8'h80;

   // Chaining value at the start of each message.
   localparam logic [31:0] HASH_INIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // Round constants.
   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

`default_nettype wire

// ===== design/sha256_front.sv =====
// Front end: accepts request transfers, drops empty ones and classifies the rest.
`default_nettype none

module sha256_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire sha256_pkg::req_type req,
   output logic                     req_stall,
   output logic                     push_valid,
   output sha256_pkg::cmd_type      push_cmd,
   input  wire logic                push_ready
);

   logic                hold_valid_ff, hold_valid_in;
   sha256_pkg::cmd_type hold_ff, hold_in;
   logic                accept;
   logic                useful;

   // Stall only while a held item cannot move into the queue.
   assign req_stall  = hold_valid_ff & ~push_ready;
   assign accept     = req_valid & ~req_stall;
   assign useful     = req.has_data | req.finish;
   assign push_valid = hold_valid_ff;
   assign push_cmd   = hold_ff;

   // Classify the incoming transfer.
   always_comb begin
      hold_in.data_byte = req.data_byte;
      if (req.has_data && req.finish) begin
         hold_in.kind = sha256_pkg::CMD_LAST_BYTE;
      end else if (req.has_data) begin
         hold_in.kind = sha256_pkg::CMD_BYTE;
      end else begin
         hold_in.kind = sha256_pkg::CMD_FINISH;
      end
   end

   // Load on accept, drop items that carry neither a byte nor an end mark.
   always_comb begin
      if (accept) begin
         hold_valid_in = useful;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end else begin
         hold_valid_in = hold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff <= hold_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/sha256_queue.sv =====
// Small command queue between the front end and the hashing engine.
`default_nettype none

module sha256_queue #(
   parameter int Depth = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   input  wire sha256_pkg::cmd_type push_cmd,
   output logic                     push_ready,
   output logic                     head_valid,
   output sha256_pkg::cmd_type      head_cmd,
   input  wire logic                pop
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   sha256_pkg::cmd_type entry_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (count_ff != CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop & head_valid;

   // Advance pointers with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== design/sha256_back.sv =====
// Hashing engine: block buffer, padding sequencer, round unit and digest output.
`default_nettype none

module sha256_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                cmd_valid,
   input  wire sha256_pkg::cmd_type cmd,
   output logic                     cmd_pop,
   output logic                     rsp_valid,
   output sha256_pkg::rsp_type      rsp,
   input  wire logic                rsp_stall
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_MARK  = 6'b000010,
      S_ZERO  = 6'b000100,
      S_ROUND = 6'b001000,
      S_FINAL = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   // What follows a compression.
   typedef enum logic [1:0] {
      AFT_DATA = 2'd0,
      AFT_ZERO = 2'd1,
      AFT_OUT  = 2'd2
   } after_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
      rotr = (x >> n) | (x << (6'd32 - {1'b0, n}));
   endfunction

   function automatic logic [31:0] big_sig0(input logic [31:0] x);
      big_sig0 = rotr(x, 5'd2) ^ rotr(x, 5'd13) ^ rotr(x, 5'd22);
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] x);
      big_sig1 = rotr(x, 5'd6) ^ rotr(x, 5'd11) ^ rotr(x, 5'd25);
   endfunction

   function automatic logic [31:0] small_sig0(input logic [31:0] x);
      small_sig0 = rotr(x, 5'd7) ^ rotr(x, 5'd18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sig1(input logic [31:0] x);
      small_sig1 = rotr(x, 5'd17) ^ rotr(x, 5'd19) ^ (x >> 10);
   endfunction

   state_type           state_ff, state_in;
   after_type           after_ff, after_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [60:0]         count_ff, count_in;
   logic                fin_ff, fin_in;
   logic                fill_end_ff, fill_end_in;
   logic [5:0]          round_ff, round_in;
   logic [2:0]          idx_ff, idx_in;
   logic [31:0]         chain_ff [8];
   logic [31:0]         v_ff [8];
   logic [31:0]         w_ff [16];
   logic                rsp_valid_ff, rsp_valid_in;
   sha256_pkg::rsp_type rsp_ff;

   logic                wr_en;
   logic [7:0]          wr_byte;
   logic                len_wr;
   logic                start;
   logic                out_load;
   logic                out_free;
   logic                msg_done;
   logic [31:0]         t1, t2, choose, major, w_new;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   // One round of the compression function and the next schedule word.
   always_comb begin
      choose = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      major  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t1     = v_ff[7] + big_sig1(v_ff[4]) + choose + sha256_pkg::ROUND_K[round_ff] + w_ff[0];
      t2     = big_sig0(v_ff[0]) + major;
      w_new  = small_sig1(w_ff[14]) + w_ff[9] + small_sig0(w_ff[1]) + w_ff[0];
   end

   // Sequence bytes, padding, compressions and digest output.
   always_comb begin
      state_in    = state_ff;
      after_in    = after_ff;
      cnt_in      = cnt_ff;
      count_in    = count_ff;
      fin_in      = fin_ff;
      fill_end_in = fill_end_ff;
      round_in    = round_ff;
      idx_in      = idx_ff;
      wr_en       = 1'b0;
      wr_byte     = '0;
      len_wr      = 1'b0;
      start       = 1'b0;
      cmd_pop     = 1'b0;
      out_load    = 1'b0;
      msg_done    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.kind == sha256_pkg::CMD_FINISH) begin
                  state_in = S_MARK;
               end else begin
                  wr_en    = 1'b1;
                  wr_byte  = cmd.data_byte;
                  cnt_in   = cnt_ff + 1'b1;
                  count_in = count_ff + 1'b1;
                  fin_in   = (cmd.kind == sha256_pkg::CMD_LAST_BYTE);
                  if (cnt_ff == 6'd63) begin
                     start    = 1'b1;
                     after_in = AFT_DATA;
                     state_in = S_ROUND;
                  end else if (cmd.kind == sha256_pkg::CMD_LAST_BYTE) begin
                     state_in = S_MARK;
                  end
               end
            end
         end
         S_MARK: begin
            wr_en       = 1'b1;
            wr_byte     = sha256_pkg::PAD_MARK;
            cnt_in      = cnt_ff + 1'b1;
            fin_in      = 1'b0;
            // No room left for the length after the marker: zero-fill to block end.
            fill_end_in = (cnt_ff >= 6'd56) && (cnt_ff != 6'd63);
            if (cnt_ff == 6'd63) begin
               start    = 1'b1;
               after_in = AFT_ZERO;
               state_in = S_ROUND;
            end else begin
               state_in = S_ZERO;
            end
         end
         S_ZERO: begin
            if ((cnt_ff == 6'd56) && !fill_end_ff) begin
               len_wr   = 1'b1;
               start    = 1'b1;
               after_in = AFT_OUT;
               state_in = S_ROUND;
            end else begin
               wr_en  = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == 6'd63) begin
                  start       = 1'b1;
                  after_in    = AFT_ZERO;
                  fill_end_in = 1'b0;
                  state_in    = S_ROUND;
               end
            end
         end
         S_ROUND: begin
            round_in = round_ff + 1'b1;
            if (round_ff == 6'd63) begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            case (after_ff)
               AFT_DATA: state_in = fin_ff ? S_MARK : S_IDLE;
               AFT_ZERO: state_in = S_ZERO;
               AFT_OUT: begin
                  idx_in   = '0;
                  state_in = S_OUT;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               idx_in   = idx_ff + 1'b1;
               if (idx_ff == 3'd7) begin
                  msg_done = 1'b1;
                  cnt_in   = '0;
                  count_in = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (start) begin
         round_in = '0;
      end
   end

   // Hold the response until the receiver takes the transfer.
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         after_ff     <= AFT_DATA;
         cnt_ff       <= '0;
         count_ff     <= '0;
         fin_ff       <= 1'b0;
         fill_end_ff  <= 1'b0;
         round_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         after_ff     <= after_in;
         cnt_ff       <= cnt_in;
         count_ff     <= count_in;
         fin_ff       <= fin_in;
         fill_end_ff  <= fill_end_in;
         round_ff     <= round_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Fold the working variables into the chain; restart it after a digest.
   always_ff @(posedge clock) begin
      if (reset || msg_done) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= sha256_pkg::HASH_INIT[i];
         end
      end else if (state_ff == S_FINAL) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= chain_ff[i] + v_ff[i];
         end
      end
   end

   // Load working variables at block start, advance one round per cycle.
   always_ff @(posedge clock) begin
      if (start) begin
         for (int i = 0; i < 8; i++) begin
            v_ff[i] <= chain_ff[i];
         end
      end else if (state_ff == S_ROUND) begin
         v_ff[0] <= t1 + t2;
         v_ff[1] <= v_ff[0];
         v_ff[2] <= v_ff[1];
         v_ff[3] <= v_ff[2];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[5] <= v_ff[4];
         v_ff[6] <= v_ff[5];
         v_ff[7] <= v_ff[6];
      end
   end

   // Block buffer doubles as the schedule window during the rounds.
   always_ff @(posedge clock) begin
      if (state_ff == S_ROUND) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[15] <= w_new;
      end else if (len_wr) begin
         w_ff[14] <= count_ff[60:29];
         w_ff[15] <= {count_ff[28:0], 3'b000};
      end else if (wr_en) begin
         w_ff[cnt_ff[5:2]][{~cnt_ff[1:0], 3'b000} +: 8] <= wr_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff.digest_word <= chain_ff[idx_ff];
         rsp_ff.word_index  <= idx_ff;
         rsp_ff.last_word   <= (idx_ff == 3'd7);
      end
   end

endmodule

`default_nettype wire

// ===== design/sha256_stream_hasher.sv =====
// Top level of the SHA-256 byte stream hasher.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_stall  sha256_pkg::req_type
//   rsp_     out        rsp_valid / rsp_stall  sha256_pkg::rsp_type
//
// Each data byte is written into the block buffer; every 64th byte starts a compression
// that runs one round per cycle in a single round unit, during which the command queue
// keeps taking transfers until full. An end mark leads to byte-wise padding and length
// loading, one or two compressions and eight digest transfers.
// Reset is synchronous and leaves the hasher at the initial chaining value.
// A stalled response holds the engine; a full queue stalls the request side.
`default_nettype none

module sha256_stream_hasher #(
   parameter int QueueDepth = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire sha256_pkg::req_type req,
   output logic                     req_stall,
   output logic                     rsp_valid,
   output sha256_pkg::rsp_type      rsp,
   input  wire logic                rsp_stall
);

   logic                push_valid;
   logic                push_ready;
   sha256_pkg::cmd_type push_cmd;
   logic                head_valid;
   sha256_pkg::cmd_type head_cmd;
   logic                head_pop;

   sha256_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req        (req),
      .req_stall  (req_stall),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   sha256_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (head_pop)
   );

   sha256_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (head_valid),
      .cmd       (head_cmd),
      .cmd_pop   (head_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_stall (rsp_stall)
   );

endmodule

`default_nettype wire

// ===== test/tb_sha256_stream_hasher.sv =====
// Self-checking testbench for the SHA-256 byte stream hasher.
`timescale 1ns / 100ps

// Chaining value at the start of every message.
localparam bit [31:0] HASH_IV [8] = '{
   32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
   32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
};

// Per-round additive constants.
localparam bit [31:0] ROUND_CONST [64] = '{
   32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
   32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
   32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
   32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
   32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
   32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
   32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
   32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
   32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
   32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
   32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
   32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
   32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
   32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
   32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
   32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
};

// Padding marker that follows the last message byte.
localparam bit [7:0] PAD_BYTE = 8'h80;

// Tracks the hash state of the stream and the digest words still owed by the block.
class digest_tracker;
   bit [31:0] chain [8];
   bit [7:0]  block_bytes [64];
   int unsigned fill;
   bit [60:0] byte_count;
   sha256_pkg::rsp_type owed_words [$];
   int unsigned failures;
   int unsigned words_checked;
   int unsigned messages;

   function new();
      failures = 0;
      words_checked = 0;
      messages = 0;
      restart();
   endfunction

   function void restart();
      foreach (chain[i]) chain[i] = HASH_IV[i];
      fill = 0;
      byte_count = '0;
   endfunction

   function bit [31:0] rotr(bit [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Run the 64 rounds over the buffered block and fold into the chain.
   function void compress();
      bit [31:0] w [64];
      bit [31:0] v [8];
      bit [31:0] s0, s1, t1, t2;
      int i;
      for (i = 0; i < 16; i++)
         w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      for (i = 16; i < 64; i++) begin
         s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (i = 0; i < 8; i++) v[i] = chain[i];
      for (i = 0; i < 64; i++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (i = 0; i < 8; i++) chain[i] += v[i];
   endfunction

   // Note an accepted request transfer; an end mark queues the eight digest words.
   function void note_transfer(sha256_pkg::req_type item);
      bit [63:0] bit_len;
      sha256_pkg::rsp_type word;
      int i;
      if (item.has_data) begin
         block_bytes[fill] = item.data_byte;
         fill++;
         byte_count++;
         if (fill == 64) begin
            compress();
            fill = 0;
         end
      end
      if (!item.finish) return;

      // Pad: marker, zeros, then the big-endian bit length, spilling to a second block.
      bit_len = {byte_count, 3'b000};
      block_bytes[fill] = PAD_BYTE;
      fill++;
      if (fill > 56) begin
         while (fill < 64) begin
            block_bytes[fill] = 8'h00;
            fill++;
         end
         compress();
         fill = 0;
      end
      while (fill < 56) begin
         block_bytes[fill] = 8'h00;
         fill++;
      end
      for (i = 0; i < 8; i++) block_bytes[56+i] = bit_len[63-8*i -: 8];
      compress();

      for (i = 0; i < 8; i++) begin
         word.digest_word = chain[i];
         word.word_index  = i[2:0];
         word.last_word   = (i == 7);
         owed_words.push_back(word);
      end
      messages++;
      restart();
   endfunction

   // Compare one accepted digest word against the oldest owed word.
   function void check_word(sha256_pkg::rsp_type got);
      sha256_pkg::rsp_type want;
      if (owed_words.size() == 0) begin
         $error("unexpected digest word %h index %0d last %0b",
                got.digest_word, got.word_index, got.last_word);
         failures++;
         return;
      end
      want = owed_words.pop_front();
      words_checked++;
      if (got.digest_word !== want.digest_word) begin
         $error("digest_word: expected %h, got %h", want.digest_word, got.digest_word);
         failures++;
      end
      if (got.word_index !== want.word_index) begin
         $error("word_index: expected %0d, got %0d", want.word_index, got.word_index);
         failures++;
      end
      if (got.last_word !== want.last_word) begin
         $error("last_word: expected %0b, got %0b", want.last_word, got.last_word);
         failures++;
      end
   endfunction
endclass

module tb_sha256_stream_hasher;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   sha256_pkg::req_type req = '0;
   logic                req_stall;
   logic                rsp_valid;
   sha256_pkg::rsp_type rsp;
   logic                rsp_stall = 1'b0;

   // Traffic knobs, percent per cycle, plus the long output hold.
   int unsigned req_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   logic        hold_rsp = 1'b0;

   int unsigned   bytes_sent = 0;
   int unsigned   noise_sent = 0;
   digest_tracker tracker = new();

   sha256_stream_hasher u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req       (req),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_stall (rsp_stall)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Check accepted digest words, then pick the stall for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_word(rsp);
      rsp_stall <= hold_rsp || ($urandom_range(99) < rsp_stall_pct);
   end

   // Offer one request transfer after a random idle gap and hold it until taken.
   task automatic send_item(input sha256_pkg::req_type item);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req <= item;
      do @(posedge clock); while (req_stall);
      tracker.note_transfer(item);
      if (item.has_data || item.finish) bytes_sent++;
      else noise_sent++;
   endtask

   task automatic send_req(input logic [7:0] data, input logic has_data, input logic finish);
      sha256_pkg::req_type item;
      item.data_byte = data;
      item.has_data  = has_data;
      item.finish    = finish;
      send_item(item);
   endtask

   // Send a message of random bytes; the end mark rides on the last byte or stands alone.
   task automatic send_message(input int len, input bit mark_on_last);
      int i;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0) send_req(8'($urandom_range(255)), 1'b0, 1'b0);
         send_req(8'($urandom_range(255)), 1'b1, mark_on_last && (i == len - 1));
      end
      if (!mark_on_last || len == 0) send_req(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   // Mostly short messages, some placed on the padding and block boundaries.
   function automatic int pick_length();
      int unsigned sel;
      sel = $urandom_range(9);
      if (sel >= 1) return $urandom_range(12);
      case ($urandom_range(5))
         0: return 55;
         1: return 56;
         2: return 57;
         3: return 63;
         4: return 64;
         default: return 119;
      endcase
   endfunction

   // Release the request channel and wait until every owed digest word has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.owed_words.size() != 0) @(posedge clock);
   endtask

   task automatic random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                               input int unsigned budget);
      int unsigned start;
      req_idle_pct  <= idle_pct;
      rsp_stall_pct <= stall_pct;
      start = bytes_sent;
      while (bytes_sent - start < budget)
         send_message(pick_length(), 1'($urandom_range(1)));
      drain();
   endtask

   initial begin
      int unsigned waited;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty messages, ignored items, byte extremes, split end mark, "abc".
      send_req(8'hff, 1'b0, 1'b1);
      send_req(8'h00, 1'b0, 1'b1);
      send_req(8'ha5, 1'b0, 1'b0);
      send_req(8'h00, 1'b1, 1'b1);
      send_req(8'hff, 1'b1, 1'b1);
      send_req(PAD_BYTE, 1'b1, 1'b0);
      send_req(8'h5a, 1'b0, 1'b0);
      send_req(8'h00, 1'b0, 1'b1);
      send_req(8'h61, 1'b1, 1'b0);
      send_req(8'h62, 1'b1, 1'b0);
      send_req(8'h63, 1'b1, 1'b0);
      send_req(8'h00, 1'b0, 1'b1);
      drain();

      // Random traffic under each idling mix.
      random_phase(0, 0, 10);
      random_phase(51, 0, 10);
      random_phase(0, 51, 10);
      random_phase(17, 17, 10);

      // Hold the output for a long stretch while requests keep coming.
      req_idle_pct  <= 0;
      rsp_stall_pct <= 0;
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (600) @(posedge clock);
            hold_rsp <= 1'b0;
         end
      join_none
      repeat (6) send_message($urandom_range(6, 2), 1'($urandom_range(1)));
      drain();

      // Wind down with a bounded wait for stragglers.
      req_valid <= 1'b0;
      waited = 0;
      while (tracker.owed_words.size() != 0 && waited < 50000) begin
         @(posedge clock);
         waited++;
      end
      repeat (200) @(posedge clock);
      while (tracker.owed_words.size() != 0) begin
         $error("digest word %h index %0d never arrived",
                tracker.owed_words[0].digest_word, tracker.owed_words[0].word_index);
         void'(tracker.owed_words.pop_front());
         tracker.failures++;
      end

      $display("Hashed %0d messages from %0d data and end-mark transfers (%0d ignored items),",
               tracker.messages, bytes_sent, noise_sent);
      $display("comparing %0d digest words under free, idle, stalled and held-output traffic.",
               tracker.words_checked);
      if (tracker.failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/sha256_pkg.sv
design/sha256_front.sv
design/sha256_queue.sv
design/sha256_back.sv
design/sha256_stream_hasher.sv
test/tb_sha256_stream_hasher.sv
